// ===== design/apct_pkg.sv =====
// ----------------------------------------------------------------------------
// apct_pkg
// shared types and constants for the adc and port change trigger unit
// ----------------------------------------------------------------------------
package apct_pkg;

    localparam int NumAdc        = 5;   // stored adc channels
    localparam int NumPorts      = 3;   // stored ports
    localparam int AdcChannels   = 5;   // channels that are compared (1 to 5)
    localparam int PortCount     = 3;   // ports that are compared (1 to 3)
    localparam int AdcWidth      = 10;
    localparam int PortWidth     = 8;
    localparam int TrigWidth     = 9;
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 8;
    localparam int PortTrigShift = 5;
    localparam int FirstSampleBit = 8;

    localparam logic [AdcWidth-1:0] AdcMoveLimit = AdcWidth'(15);

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_P1_DIR    = 3'd0,
        CFG_P2_DIR    = 3'd1,
        CFG_P3_DIR    = 3'd2,
        CFG_ADC_PIN   = 3'd3,
        CFG_P1_AVAIL  = 3'd4,
        CFG_P2_AVAIL  = 3'd5,
        CFG_P3_AVAIL  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [AdcWidth-1:0]  adc_ch0;
        logic [AdcWidth-1:0]  adc_ch1;
        logic [AdcWidth-1:0]  adc_ch2;
        logic [AdcWidth-1:0]  adc_ch3;
        logic [AdcWidth-1:0]  adc_ch4;
        logic [PortWidth-1:0] p1_pins;
        logic [PortWidth-1:0] p2_pins;
        logic [PortWidth-1:0] p3_pins;
        logic                 return_pending;
    } in_item_t;

    typedef struct packed {
        logic [TrigWidth-1:0] trigger;
        logic [PortWidth-1:0] p1_state;
        logic [PortWidth-1:0] p2_state;
        logic [PortWidth-1:0] p3_state;
    } out_item_t;

    typedef struct packed {
        logic [PortWidth-1:0] p1_dir_mask;
        logic [PortWidth-1:0] p2_dir_mask;
        logic [PortWidth-1:0] p3_dir_mask;
        logic [PortWidth-1:0] adc_pin_mask;
        logic [PortWidth-1:0] p1_avail_mask;
        logic [PortWidth-1:0] p2_avail_mask;
        logic [PortWidth-1:0] p3_avail_mask;
    } cfg_t;

    typedef struct packed {
        logic                                primed;
        logic [NumPorts-1:0][PortWidth-1:0]  last_port;
        logic [NumAdc-1:0][AdcWidth-1:0]     last_reading;
    } state_t;

    typedef struct packed {
        logic                                update;
        logic [NumPorts-1:0][PortWidth-1:0]  port;
        logic [NumAdc-1:0][AdcWidth-1:0]     reading;
        out_item_t                           result;
    } detect_t;

endpackage

// ===== design/apct_in_stage.sv =====
// ----------------------------------------------------------------------------
// apct_in_stage
// input register: holds one request until the result stage takes it
// ----------------------------------------------------------------------------
module apct_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  apct_pkg::in_item_t in_data,
    input  logic              take,
    output logic              stage_valid,
    output apct_pkg::in_item_t stage_item
);

    logic               valid_reg;
    logic               valid_next;
    apct_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ===== design/apct_detect.sv =====
// ----------------------------------------------------------------------------
// apct_detect
// pin masking, adc movement and port change compare, trigger word
// ----------------------------------------------------------------------------
module apct_detect (
    input  apct_pkg::in_item_t item,
    input  apct_pkg::cfg_t     cfg,
    input  apct_pkg::state_t   st,
    output apct_pkg::detect_t  det
);

    logic [apct_pkg::NumAdc-1:0][apct_pkg::AdcWidth-1:0]    adc;
    logic [apct_pkg::NumPorts-1:0][apct_pkg::PortWidth-1:0] ports;
    logic [apct_pkg::NumAdc-1:0]                            adc_en;
    logic [apct_pkg::NumAdc-1:0]                            adc_moved;
    logic [apct_pkg::NumPorts-1:0]                          port_changed;
    logic [apct_pkg::TrigWidth-1:0]                         trig;

    assign adc[0] = item.adc_ch0;
    assign adc[1] = item.adc_ch1;
    assign adc[2] = item.adc_ch2;
    assign adc[3] = item.adc_ch3;
    assign adc[4] = item.adc_ch4;

    assign ports[0] = cfg.p1_avail_mask & item.p1_pins & ~cfg.p1_dir_mask & ~cfg.adc_pin_mask;
    assign ports[1] = cfg.p2_avail_mask & item.p2_pins & ~cfg.p2_dir_mask;
    assign ports[2] = cfg.p3_avail_mask & item.p3_pins & ~cfg.p3_dir_mask;

    // channel enables come from the adc mask in reversed bit order
    for (genvar i = 0; i < apct_pkg::NumAdc; i++)
    begin : g_adc
        if (i < apct_pkg::AdcChannels)
        begin : g_on
            assign adc_en[i] = cfg.adc_pin_mask[apct_pkg::AdcChannels-1-i];
        end
        else
        begin : g_off
            assign adc_en[i] = 1'b0;
        end
        assign adc_moved[i] = adc_en[i] &&
            ((adc[i] >= st.last_reading[i]) ?
                ((adc[i] - st.last_reading[i]) > apct_pkg::AdcMoveLimit) :
                ((st.last_reading[i] - adc[i]) > apct_pkg::AdcMoveLimit));
    end

    for (genvar p = 0; p < apct_pkg::NumPorts; p++)
    begin : g_port
        if (p < apct_pkg::PortCount)
        begin : g_on
            assign port_changed[p] = (ports[p] != st.last_port[p]);
        end
        else
        begin : g_off
            assign port_changed[p] = 1'b0;
        end
    end

    always_comb
    begin
        trig = '0;
        if (item.return_pending)
        begin
            trig = '0;
        end
        else if (!st.primed)
        begin
            trig[apct_pkg::FirstSampleBit] = 1'b1;
        end
        else
        begin
            trig[apct_pkg::NumAdc-1:0] = adc_moved;
            trig[apct_pkg::PortTrigShift +: apct_pkg::NumPorts] = port_changed;
        end
    end

    always_comb
    begin
        det.update         = !item.return_pending && (trig != '0);
        det.port           = ports;
        det.reading        = adc;
        det.result.trigger = trig;
        if (item.return_pending)
        begin
            det.result.p1_state = '0;
            det.result.p2_state = '0;
            det.result.p3_state = '0;
        end
        else
        begin
            det.result.p1_state = ports[0];
            det.result.p2_state = ports[1];
            det.result.p3_state = ports[2];
        end
    end

endmodule

// ===== design/apct_result_stage.sv =====
// ----------------------------------------------------------------------------
// apct_result_stage
// stored sample, primed flag and the result register
// ----------------------------------------------------------------------------
module apct_result_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stage_valid,
    input  apct_pkg::detect_t   det,
    output logic                take,
    output apct_pkg::state_t    st,
    output logic                out_valid,
    input  logic                out_ready,
    output apct_pkg::out_item_t out_data
);

    logic                out_valid_reg;
    logic                out_valid_next;
    apct_pkg::out_item_t out_data_reg;
    apct_pkg::state_t    st_reg;
    apct_pkg::state_t    st_next;

    assign take           = stage_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_comb
    begin
        st_next = st_reg;
        if (take && det.update)
        begin
            st_next.primed       = 1'b1;
            st_next.last_port    = det.port;
            st_next.last_reading = det.reading;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= det.result;
        end
    end

    assign st        = st_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/adc_port_change_trigger_unit.sv =====
// ----------------------------------------------------------------------------
// adc_port_change_trigger_unit
// flags adc channels that moved and ports whose pins changed since the last
// stored sample, and reports the masked port states of every request that has no
// pending return
// path: input accept goes through the input register, then the result register, to out_valid
// throughput: one request per cycle while out_ready allows; the compare against the stored sample is one
//   combinational step, and the stored sample updates as a triggering request enters the result register
// reset: clears stored readings, port states and the primed flag, sets config masks
//   to their defaults (direction and adc masks 0, available masks all ones), empties both stages
module adc_port_change_trigger_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input requests
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  apct_pkg::in_item_t                   in_data,
    // results
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output apct_pkg::out_item_t                  out_data,
    // configuration write port
    input  logic                                 cfg_write,
    input  logic [apct_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [apct_pkg::CfgDataWidth-1:0]    cfg_data
);

    apct_pkg::cfg_t     cfg_reg;
    apct_pkg::cfg_t     cfg_next;
    logic               stage_valid;
    apct_pkg::in_item_t stage_item;
    logic               take;
    apct_pkg::state_t   st;
    apct_pkg::detect_t  det;

    // configuration registers; the user must write them only while the unit is idle, the block does not enforce it
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (apct_pkg::cfg_index_t'(cfg_index))
                apct_pkg::CFG_P1_DIR:   cfg_next.p1_dir_mask   = cfg_data;
                apct_pkg::CFG_P2_DIR:   cfg_next.p2_dir_mask   = cfg_data;
                apct_pkg::CFG_P3_DIR:   cfg_next.p3_dir_mask   = cfg_data;
                apct_pkg::CFG_ADC_PIN:  cfg_next.adc_pin_mask  = cfg_data;
                apct_pkg::CFG_P1_AVAIL: cfg_next.p1_avail_mask = cfg_data;
                apct_pkg::CFG_P2_AVAIL: cfg_next.p2_avail_mask = cfg_data;
                apct_pkg::CFG_P3_AVAIL: cfg_next.p3_avail_mask = cfg_data;
                default:                cfg_next = cfg_reg;  // unused index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.p1_dir_mask   <= '0;
            cfg_reg.p2_dir_mask   <= '0;
            cfg_reg.p3_dir_mask   <= '0;
            cfg_reg.adc_pin_mask  <= '0;
            cfg_reg.p1_avail_mask <= '1;
            cfg_reg.p2_avail_mask <= '1;
            cfg_reg.p3_avail_mask <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input register; frees up whenever the result stage takes its request
    apct_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    // masking and compare against the stored sample
    apct_detect u_detect (
        .item (stage_item),
        .cfg  (cfg_reg),
        .st   (st),
        .det  (det)
    );

    // stored sample plus result register; the sample is replaced on any trigger
    apct_result_stage u_result_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .det         (det),
        .take        (take),
        .st          (st),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // a pending return yields an all-zero result
    a_return_zero : assert property (@(posedge clk) disable iff (!rst_n)
        take && stage_item.return_pending |=> out_valid && (out_data == '0))
        else $error("pending return did not give a zero result");

    // the first sample flag never comes with other trigger bits
    a_first_alone : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.trigger[apct_pkg::FirstSampleBit] |->
            (out_data.trigger[apct_pkg::FirstSampleBit-1:0] == '0))
        else $error("first sample flag mixed with change bits");

    // the first real sample after reset reports the first sample flag
    a_first_flag : assert property (@(posedge clk) disable iff (!rst_n)
        take && !st.primed && !stage_item.return_pending |=>
            out_data.trigger[apct_pkg::FirstSampleBit])
        else $error("first sample flag missing");

    // any nonzero trigger leaves the unit primed
    a_primed : assert property (@(posedge clk) disable iff (!rst_n)
        take && det.update |=> st.primed)
        else $error("stored sample not marked primed after trigger");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for adc_port_change_trigger_unit: a queue-fed driver
// offers sample requests, a monitor predicts each accepted request with its
// own copy of the stored sample and the mask registers, and checks every
// result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
    import apct_pkg::*;

    localparam int IdleLimit  = 4000;  // cycles without any accept before giving up
    localparam int HoldCycles = 300;   // long receiver hold-off
    localparam int PhaseItems = 256;   // random requests per mask setting
    localparam int NumPhases  = 6;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_write = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data  = '0;

    // stimulus and scoreboard storage
    in_item_t    pending_q[$];
    out_item_t   trigger_q[$];
    logic        in_taken  = 1'b0;
    int          err_count = 0;
    int          idle_cycles = 0;

    // idling knobs, in percent, and the long hold-off request
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req  = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    // predictor copy of the mask registers and of the stored sample
    cfg_t                 masks;
    logic [AdcWidth-1:0]  held_reading [NumAdc];
    logic [PortWidth-1:0] held_port [NumPorts];
    logic                 held_primed;

    adc_port_change_trigger_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: mask the ports, compare against the stored sample, and
    // replace the stored sample whenever anything fired
    // ------------------------------------------------------------------------
    function automatic out_item_t compute_trigger(in_item_t s);
        out_item_t            r;
        logic [AdcWidth-1:0]  adc [NumAdc];
        logic [PortWidth-1:0] port [NumPorts];
        logic [TrigWidth-1:0] trig;
        int                   d;
        r = '0;
        trig = '0;
        if (s.return_pending)
        begin
            // command return pending: nothing is checked, nothing stored
            return r;
        end
        adc[0] = s.adc_ch0;
        adc[1] = s.adc_ch1;
        adc[2] = s.adc_ch2;
        adc[3] = s.adc_ch3;
        adc[4] = s.adc_ch4;
        port[0] = masks.p1_avail_mask & s.p1_pins & ~masks.p1_dir_mask & ~masks.adc_pin_mask;
        port[1] = masks.p2_avail_mask & s.p2_pins & ~masks.p2_dir_mask;
        port[2] = masks.p3_avail_mask & s.p3_pins & ~masks.p3_dir_mask;
        if (held_primed)
        begin
            for (int i = 0; i < AdcChannels && i < NumAdc; i++)
            begin
                // channel enables sit in the adc mask in reverse order
                if (masks.adc_pin_mask[AdcChannels-1-i])
                begin
                    d = int'(adc[i]) - int'(held_reading[i]);
                    if (d > int'(AdcMoveLimit) || d < -int'(AdcMoveLimit))
                        trig[i] = 1'b1;
                end
            end
            for (int i = 0; i < PortCount && i < NumPorts; i++)
            begin
                if (held_port[i] != port[i])
                    trig[PortTrigShift+i] = 1'b1;
            end
        end
        else
        begin
            // first sample after reset: no compare, flag only
            trig[FirstSampleBit] = 1'b1;
        end
        if (trig != '0)
        begin
            for (int i = 0; i < NumAdc; i++)
                held_reading[i] = adc[i];
            for (int i = 0; i < NumPorts; i++)
                held_port[i] = port[i];
            held_primed = 1'b1;
        end
        r.trigger  = trig;
        r.p1_state = port[0];
        r.p2_state = port[1];
        r.p3_state = port[2];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // driver: requests change on the falling edge; a request stays put until
    // the monitor saw it accepted on the rising edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data  <= pending_q.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HoldCycles;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check the result first, then predict the request taken on the
    // same edge, since a result always belongs to an older request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (trigger_q.size() == 0)
                begin
                    report_mismatch("result with no request pending",
                                    int'(out_data.trigger), 0);
                end
                else
                begin
                    want = trigger_q.pop_front();
                    if (out_data.trigger !== want.trigger)
                        report_mismatch("trigger", int'(out_data.trigger),
                                        int'(want.trigger));
                    if (out_data.p1_state !== want.p1_state)
                        report_mismatch("p1_state", int'(out_data.p1_state),
                                        int'(want.p1_state));
                    if (out_data.p2_state !== want.p2_state)
                        report_mismatch("p2_state", int'(out_data.p2_state),
                                        int'(want.p2_state));
                    if (out_data.p3_state !== want.p3_state)
                        report_mismatch("p3_state", int'(out_data.p3_state),
                                        int'(want.p3_state));
                end
            end
            if (in_valid && in_ready)
                trigger_q.push_back(compute_trigger(in_data));
            in_taken <= in_valid && in_ready;
        end
    end

    // watchdog: any accept or register write counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("timeout: no progress for %0d cycles", IdleLimit);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic cfg_put(input cfg_index_t idx, input logic [CfgDataWidth-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    // only called with the block idle, so the predictor copy can switch now
    task automatic load_masks(input cfg_t c);
        cfg_put(CFG_P1_DIR,   c.p1_dir_mask);
        cfg_put(CFG_P2_DIR,   c.p2_dir_mask);
        cfg_put(CFG_P3_DIR,   c.p3_dir_mask);
        cfg_put(CFG_ADC_PIN,  c.adc_pin_mask);
        cfg_put(CFG_P1_AVAIL, c.p1_avail_mask);
        cfg_put(CFG_P2_AVAIL, c.p2_avail_mask);
        cfg_put(CFG_P3_AVAIL, c.p3_avail_mask);
        @(negedge clk);
        cfg_write <= 1'b0;
        masks = c;
    endtask

    // wait until every request went in and every result came back; checked
    // at the rising edge, where the driver's signals are settled
    task automatic drain_requests();
        while (pending_q.size() != 0 || in_valid || trigger_q.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic in_item_t sample_of(input logic [AdcWidth-1:0] a,
                                           input logic [PortWidth-1:0] p1,
                                           input logic [PortWidth-1:0] p2,
                                           input logic [PortWidth-1:0] p3,
                                           input logic rp);
        in_item_t s;
        s.adc_ch0 = a;
        s.adc_ch1 = a;
        s.adc_ch2 = a;
        s.adc_ch3 = a;
        s.adc_ch4 = a;
        s.p1_pins = p1;
        s.p2_pins = p2;
        s.p3_pins = p3;
        s.return_pending = rp;
        return s;
    endfunction

    // move a reading around the 15-count threshold, now and then far away
    function automatic logic [AdcWidth-1:0] nudge_reading(input logic [AdcWidth-1:0] v);
        int d;
        int r;
        case ($urandom_range(7))
            0: d = 15;
            1: d = -15;
            2: d = 16;
            3: d = -16;
            4: d = 0;
            5: d = int'($urandom_range(30)) - 15;
            6: d = int'($urandom_range(80)) - 40;
            default: return AdcWidth'($urandom);
        endcase
        r = int'(v) + d;
        if (r < 0)
            r = 0;
        if (r > 1023)
            r = 1023;
        return AdcWidth'(r);
    endfunction

    function automatic logic [PortWidth-1:0] nudge_pins(input logic [PortWidth-1:0] p);
        case ($urandom_range(3))
            0, 1: return p;
            2: return p ^ (PortWidth'(1) << $urandom_range(PortWidth-1));
            default: return PortWidth'($urandom);
        endcase
    endfunction

    // mostly small moves from the previous request, some fully random ones
    function automatic in_item_t vary_sample(input in_item_t prev);
        in_item_t s;
        if ($urandom_range(99) < 12)
        begin
            s.adc_ch0 = AdcWidth'($urandom);
            s.adc_ch1 = AdcWidth'($urandom);
            s.adc_ch2 = AdcWidth'($urandom);
            s.adc_ch3 = AdcWidth'($urandom);
            s.adc_ch4 = AdcWidth'($urandom);
            s.p1_pins = PortWidth'($urandom);
            s.p2_pins = PortWidth'($urandom);
            s.p3_pins = PortWidth'($urandom);
        end
        else
        begin
            s.adc_ch0 = nudge_reading(prev.adc_ch0);
            s.adc_ch1 = nudge_reading(prev.adc_ch1);
            s.adc_ch2 = nudge_reading(prev.adc_ch2);
            s.adc_ch3 = nudge_reading(prev.adc_ch3);
            s.adc_ch4 = nudge_reading(prev.adc_ch4);
            s.p1_pins = nudge_pins(prev.p1_pins);
            s.p2_pins = nudge_pins(prev.p2_pins);
            s.p3_pins = nudge_pins(prev.p3_pins);
        end
        s.return_pending = ($urandom_range(9) == 0);
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_t     c;
        in_item_t s;
        in_item_t prev;

        masks.p1_dir_mask   = '0;
        masks.p2_dir_mask   = '0;
        masks.p3_dir_mask   = '0;
        masks.adc_pin_mask  = '0;
        masks.p1_avail_mask = '1;
        masks.p2_avail_mask = '1;
        masks.p3_avail_mask = '1;
        for (int i = 0; i < NumAdc; i++)
            held_reading[i] = '0;
        for (int i = 0; i < NumPorts; i++)
            held_port[i] = '0;
        held_primed = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: all five channels enabled, every port pin monitored but the port 1 pins under the adc mask
        send_idle_pct = 16;
        recv_idle_pct = 59;
        c = masks;
        c.adc_pin_mask = 8'h1f;
        load_masks(c);

        // return pending before the very first sample must not prime
        pending_q.push_back(sample_of(10'd1023, 8'hff, 8'hff, 8'hff, 1'b1));
        // first sample flags only the first-sample bit
        pending_q.push_back(sample_of(10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
        pending_q.push_back(sample_of(10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
        // threshold: 15 stays quiet, 16 fires, both directions
        pending_q.push_back(sample_of(10'd15, 8'h00, 8'h00, 8'h00, 1'b0));
        pending_q.push_back(sample_of(10'd16, 8'h00, 8'h00, 8'h00, 1'b0));
        pending_q.push_back(sample_of(10'd1, 8'h00, 8'h00, 8'h00, 1'b0));
        pending_q.push_back(sample_of(10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
        // full scale with all ports changing
        pending_q.push_back(sample_of(10'd1023, 8'hff, 8'hff, 8'hff, 1'b0));
        pending_q.push_back(sample_of(10'd0, 8'h00, 8'h00, 8'h00, 1'b1));
        pending_q.push_back(sample_of(10'd1023, 8'hff, 8'hff, 8'hff, 1'b0));
        // one port at a time
        pending_q.push_back(sample_of(10'd1023, 8'h7f, 8'hff, 8'hff, 1'b0));
        pending_q.push_back(sample_of(10'd1023, 8'h7f, 8'hfe, 8'hff, 1'b0));
        pending_q.push_back(sample_of(10'd1023, 8'h7f, 8'hfe, 8'h7f, 1'b0));
        // a single channel moving
        s = sample_of(10'd1023, 8'h7f, 8'hfe, 8'h7f, 1'b0);
        s.adc_ch2 = 10'd1000;
        pending_q.push_back(s);
        // distinct readings per channel
        s.adc_ch0 = 10'd100;
        s.adc_ch1 = 10'd1008;
        s.adc_ch2 = 10'd985;
        s.adc_ch3 = 10'd512;
        s.adc_ch4 = 10'd1023;
        pending_q.push_back(s);
        // port 1 pins owned by the adc are masked: only the adc bits fire
        pending_q.push_back(sample_of(10'd0, 8'h60, 8'hfe, 8'h7f, 1'b0));
        pending_q.push_back(sample_of(10'd0, 8'h60, 8'hfe, 8'h7f, 1'b0));
        drain_requests();

        prev = sample_of(10'd512, 8'h00, 8'h00, 8'h00, 1'b0);
        for (int ph = 0; ph < NumPhases; ph++)
        begin
            // idling: sender light and receiver heavy, then swapped, then none
            if (ph < 2)
            begin
                send_idle_pct = 16;
                recv_idle_pct = 59;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (ph)
                0:
                begin
                    // everything cleared: ports read zero and no channel is compared
                    c = '0;
                end
                1:
                begin
                    // everything set: ports read zero, all channels compared
                    c = '1;
                end
                2:
                begin
                    c = '0;
                    c.adc_pin_mask  = 8'h15;
                    c.p1_avail_mask = '1;
                    c.p2_avail_mask = '1;
                    c.p3_avail_mask = '1;
                end
                3:
                begin
                    c = '0;
                    c.adc_pin_mask  = 8'h0a;
                    c.p1_avail_mask = PortWidth'($urandom);
                    c.p2_avail_mask = PortWidth'($urandom);
                    c.p3_avail_mask = PortWidth'($urandom);
                end
                default:
                begin
                    c.p1_dir_mask   = PortWidth'($urandom) & PortWidth'($urandom);
                    c.p2_dir_mask   = PortWidth'($urandom) & PortWidth'($urandom);
                    c.p3_dir_mask   = PortWidth'($urandom) & PortWidth'($urandom);
                    c.adc_pin_mask  = PortWidth'($urandom);
                    c.p1_avail_mask = PortWidth'($urandom) | PortWidth'($urandom);
                    c.p2_avail_mask = PortWidth'($urandom) | PortWidth'($urandom);
                    c.p3_avail_mask = PortWidth'($urandom) | PortWidth'($urandom);
                end
            endcase
            load_masks(c);

            for (int n = 0; n < PhaseItems; n++)
            begin
                s = vary_sample(prev);
                pending_q.push_back(s);
                prev = s;
            end
            // receiver stalls a long time while requests keep coming
            if (ph == 4)
                hold_req++;
            drain_requests();
        end

        if (trigger_q.size() != 0)
            report_mismatch("requests never answered", trigger_q.size(), 0);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/apct_pkg.sv
design/apct_in_stage.sv
design/apct_detect.sv
design/apct_result_stage.sv
design/adc_port_change_trigger_unit.sv
tb/sv/tb.sv
